### hw/rtl/lfob_pkg.sv
`timescale 1ns / 1ps

package lfob_pkg;

    // Field and register widths
    localparam int SENSOR_BITS  = 12;
    localparam int SPEED_BITS   = 12;
    localparam int THR_BITS     = 12;
    localparam int MARGIN_BITS  = 8;
    localparam int FWD_BITS     = 10;
    localparam int DATA_BITS    = 32;
    localparam int ADDR_BITS    = 5;
    localparam int REG_IDX_BITS = 3;

    // Signed width that holds any sensor or threshold plus a sign and one spare bit
    localparam int CMP_BITS = ((SENSOR_BITS > THR_BITS) ? SENSOR_BITS : THR_BITS) + 2;

    // Signed width of 5*fwd +/- 2*d with headroom for saturation
    localparam int LAW_BASE = (SENSOR_BITS > SPEED_BITS) ? SENSOR_BITS : SPEED_BITS;
    localparam int LAW_BITS = ((LAW_BASE > 12) ? LAW_BASE : 12) + 3;

    // Divide by five as multiply by ceil(2^18/5), exact below 2^18
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_BITS  = 16;
    localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'((2 ** RECIP_SHIFT + 4) / 5);

    // Fixed wheel commands
    localparam logic signed [SPEED_BITS-1:0] SPIN_FAST        = SPEED_BITS'(200);
    localparam logic signed [SPEED_BITS-1:0] SPIN_FAST_NEG    = SPEED_BITS'(-200);
    localparam logic signed [SPEED_BITS-1:0] STEER_BACK_LEFT  = SPEED_BITS'(-200);
    localparam logic signed [SPEED_BITS-1:0] STEER_BACK_RIGHT = SPEED_BITS'(100);

    // Register reset values
    localparam logic [THR_BITS-1:0]    FRONT_THRESHOLD_RST       = THR_BITS'(300);
    localparam logic [MARGIN_BITS-1:0] SIDE_MARGIN_RST           = MARGIN_BITS'(20);
    localparam logic [THR_BITS-1:0]    SIDE_CLEAR_THRESHOLD_RST  = THR_BITS'(100);
    localparam logic [THR_BITS-1:0]    RECOVERY_THRESHOLD_RST    = THR_BITS'(80);
    localparam logic [THR_BITS-1:0]    GROUND_DARK_THRESHOLD_RST = THR_BITS'(400);
    localparam logic [FWD_BITS-1:0]    LINE_FORWARD_SPEED_RST    = FWD_BITS'(200);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FRONT_THRESHOLD       = 3'd0,
        REG_SIDE_MARGIN           = 3'd1,
        REG_SIDE_CLEAR_THRESHOLD  = 3'd2,
        REG_RECOVERY_THRESHOLD    = 3'd3,
        REG_GROUND_DARK_THRESHOLD = 3'd4,
        REG_LINE_FORWARD_SPEED    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SENSOR_BITS-1:0] front_right_prox;
        logic [SENSOR_BITS-1:0] left_side_prox;
        logic [SENSOR_BITS-1:0] left_diag_prox;
        logic [SENSOR_BITS-1:0] front_left_prox;
        logic [SENSOR_BITS-1:0] ground_left;
        logic [SENSOR_BITS-1:0] ground_center;
        logic [SENSOR_BITS-1:0] ground_right;
    } sensor_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] left_speed;
        logic signed [SPEED_BITS-1:0] right_speed;
        logic                         avoiding_flag;
        logic                         around_flag;
        logic                         recovery_flag;
        logic                         on_track_flag;
    } cmd_t;

    typedef struct packed {
        logic [THR_BITS-1:0]    front_threshold;
        logic [MARGIN_BITS-1:0] side_margin;
        logic [THR_BITS-1:0]    side_clear_threshold;
        logic [THR_BITS-1:0]    recovery_threshold;
        logic [THR_BITS-1:0]    ground_dark_threshold;
        logic [FWD_BITS-1:0]    line_forward_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] left_speed;
        logic signed [SPEED_BITS-1:0] right_speed;
    } wheel_t;

endpackage

### hw/rtl/lfob_cfg.sv
`timescale 1ns / 1ps

module lfob_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfob_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lfob_pkg::DATA_BITS-1:0] pwdata,
    output logic [lfob_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output lfob_pkg::cfg_t                 cfg
);

    lfob_pkg::cfg_t   cfg_reg;
    lfob_pkg::cfg_t   cfg_next;
    lfob_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = lfob_pkg::reg_idx_t'(paddr[lfob_pkg::ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                lfob_pkg::REG_FRONT_THRESHOLD:
                    cfg_next.front_threshold = pwdata[lfob_pkg::THR_BITS-1:0];
                lfob_pkg::REG_SIDE_MARGIN:
                    cfg_next.side_margin = pwdata[lfob_pkg::MARGIN_BITS-1:0];
                lfob_pkg::REG_SIDE_CLEAR_THRESHOLD:
                    cfg_next.side_clear_threshold = pwdata[lfob_pkg::THR_BITS-1:0];
                lfob_pkg::REG_RECOVERY_THRESHOLD:
                    cfg_next.recovery_threshold = pwdata[lfob_pkg::THR_BITS-1:0];
                lfob_pkg::REG_GROUND_DARK_THRESHOLD:
                    cfg_next.ground_dark_threshold = pwdata[lfob_pkg::THR_BITS-1:0];
                lfob_pkg::REG_LINE_FORWARD_SPEED:
                    cfg_next.line_forward_speed = pwdata[lfob_pkg::FWD_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_threshold       <= lfob_pkg::FRONT_THRESHOLD_RST;
            cfg_reg.side_margin           <= lfob_pkg::SIDE_MARGIN_RST;
            cfg_reg.side_clear_threshold  <= lfob_pkg::SIDE_CLEAR_THRESHOLD_RST;
            cfg_reg.recovery_threshold    <= lfob_pkg::RECOVERY_THRESHOLD_RST;
            cfg_reg.ground_dark_threshold <= lfob_pkg::GROUND_DARK_THRESHOLD_RST;
            cfg_reg.line_forward_speed    <= lfob_pkg::LINE_FORWARD_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        case (idx)
            lfob_pkg::REG_FRONT_THRESHOLD:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.front_threshold);
            lfob_pkg::REG_SIDE_MARGIN:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.side_margin);
            lfob_pkg::REG_SIDE_CLEAR_THRESHOLD:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.side_clear_threshold);
            lfob_pkg::REG_RECOVERY_THRESHOLD:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.recovery_threshold);
            lfob_pkg::REG_GROUND_DARK_THRESHOLD:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.ground_dark_threshold);
            lfob_pkg::REG_LINE_FORWARD_SPEED:
                prdata = lfob_pkg::DATA_BITS'(cfg_reg.line_forward_speed);
            default:
                prdata = '0;
        endcase
    end

endmodule

### hw/rtl/lfob_line_law.sv
`timescale 1ns / 1ps

module lfob_line_law
(
    input  lfob_pkg::sensor_t                item,
    input  logic [lfob_pkg::FWD_BITS-1:0]    fwd,
    output lfob_pkg::wheel_t                 law
);

    localparam int LB = lfob_pkg::LAW_BITS;
    localparam int PB = lfob_pkg::LAW_BITS + lfob_pkg::RECIP_BITS;
    localparam logic signed [LB-1:0] SPD_MAX = LB'(2 ** (lfob_pkg::SPEED_BITS - 1) - 1);
    localparam logic signed [LB-1:0] SPD_MIN = LB'(-(2 ** (lfob_pkg::SPEED_BITS - 1)));

    // Truncating divide by five, then clamp to the speed range
    function automatic logic signed [lfob_pkg::SPEED_BITS-1:0] div5_sat(
        input logic signed [LB-1:0] v);
        logic [LB-1:0]          mag;
        logic [PB-1:0]          prod;
        logic [LB-1:0]          quo;
        logic signed [LB-1:0]   q;
        mag  = v[LB-1] ? LB'(-v) : LB'(v);
        prod = PB'(mag) * PB'(lfob_pkg::RECIP_MUL);
        quo  = LB'(prod[PB-1:lfob_pkg::RECIP_SHIFT]);
        q    = v[LB-1] ? -signed'(quo) : signed'(quo);
        if (q > SPD_MAX)
            div5_sat = lfob_pkg::SPEED_BITS'(SPD_MAX);
        else if (q < SPD_MIN)
            div5_sat = lfob_pkg::SPEED_BITS'(SPD_MIN);
        else
            div5_sat = q[lfob_pkg::SPEED_BITS-1:0];
    endfunction

    logic signed [LB-1:0] gl_s;
    logic signed [LB-1:0] gr_s;
    logic signed [LB-1:0] fwd_s;
    logic signed [LB-1:0] base;
    logic signed [LB-1:0] diff2;

    // Proportional steering on the outer ground pair
    assign gl_s  = signed'(LB'(item.ground_left));
    assign gr_s  = signed'(LB'(item.ground_right));
    assign fwd_s = signed'(LB'(fwd));
    assign base  = (fwd_s <<< 2) + fwd_s;
    assign diff2 = (gr_s - gl_s) <<< 1;

    assign law.left_speed  = div5_sat(base - diff2);
    assign law.right_speed = div5_sat(base + diff2);

endmodule

### hw/rtl/lfob_ctrl.sv
`timescale 1ns / 1ps

module lfob_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lfob_pkg::sensor_t item,
    input  lfob_pkg::cfg_t    cfg,
    input  lfob_pkg::wheel_t  law,
    output lfob_pkg::cmd_t    cmd
);

    localparam int CB = lfob_pkg::CMP_BITS;

    logic                                 on_track_reg;
    logic                                 avoid_reg;
    logic                                 around_reg;
    logic                                 recover_reg;
    logic signed [lfob_pkg::SPEED_BITS-1:0] held_left_reg;
    logic signed [lfob_pkg::SPEED_BITS-1:0] held_right_reg;

    logic                                 on_track_next;
    logic                                 avoid_next;
    logic                                 around_next;
    logic                                 recover_next;
    logic signed [lfob_pkg::SPEED_BITS-1:0] held_left_next;
    logic signed [lfob_pkg::SPEED_BITS-1:0] held_right_next;
    logic signed [lfob_pkg::SPEED_BITS-1:0] left;
    logic signed [lfob_pkg::SPEED_BITS-1:0] right;

    logic signed [CB-1:0] fr_s;
    logic signed [CB-1:0] fl_s;
    logic signed [CB-1:0] side_s;
    logic signed [CB-1:0] diag_s;
    logic signed [CB-1:0] gl_s;
    logic signed [CB-1:0] gc_s;
    logic signed [CB-1:0] gr_s;
    logic signed [CB-1:0] front_th;
    logic signed [CB-1:0] clear_lvl;
    logic signed [CB-1:0] diag_th;
    logic signed [CB-1:0] rec_th;
    logic signed [CB-1:0] dark_th;
    logic                 front_hit;
    logic                 side_clear;
    logic                 ground_dark;

    // Widen everything to one signed compare width
    assign fr_s      = signed'(CB'(item.front_right_prox));
    assign fl_s      = signed'(CB'(item.front_left_prox));
    assign side_s    = signed'(CB'(item.left_side_prox));
    assign diag_s    = signed'(CB'(item.left_diag_prox));
    assign gl_s      = signed'(CB'(item.ground_left));
    assign gc_s      = signed'(CB'(item.ground_center));
    assign gr_s      = signed'(CB'(item.ground_right));
    assign front_th  = signed'(CB'(cfg.front_threshold));
    assign clear_lvl = front_th - signed'(CB'(cfg.side_margin));
    assign diag_th   = signed'(CB'(cfg.side_clear_threshold));
    assign rec_th    = signed'(CB'(cfg.recovery_threshold));
    assign dark_th   = signed'(CB'(cfg.ground_dark_threshold));

    assign front_hit   = (fl_s > front_th) || (fr_s > front_th);
    assign side_clear  = side_s < clear_lvl;
    assign ground_dark = (gl_s < dark_th) || (gc_s < dark_th) || (gr_s < dark_th);

    // Walk the mode chain in tick order
    always_comb
    begin
        held_left_next  = on_track_reg ? law.left_speed  : held_left_reg;
        held_right_next = on_track_reg ? law.right_speed : held_right_reg;
        left            = held_left_next;
        right           = held_right_next;
        on_track_next   = on_track_reg;
        avoid_next      = avoid_reg || front_hit;
        around_next     = around_reg;
        recover_next    = recover_reg;

        if (avoid_next)
        begin
            if (side_clear)
            begin
                left  = lfob_pkg::SPIN_FAST;
                right = lfob_pkg::SPIN_FAST_NEG;
            end
            else if (side_s >= front_th)
            begin
                avoid_next  = 1'b0;
                around_next = 1'b1;
            end
        end

        if (around_next)
        begin
            if (side_clear && (diag_s < diag_th))
            begin
                left  = lfob_pkg::STEER_BACK_LEFT;
                right = lfob_pkg::STEER_BACK_RIGHT;
            end
            if (ground_dark)
            begin
                around_next   = 1'b0;
                recover_next  = 1'b1;
                on_track_next = 1'b0;
            end
        end

        if (recover_next)
        begin
            if (side_s > rec_th)
            begin
                left  = lfob_pkg::SPIN_FAST;
                right = lfob_pkg::SPIN_FAST_NEG;
            end
            else
            begin
                recover_next  = 1'b0;
                on_track_next = 1'b1;
            end
        end
    end

    assign cmd.left_speed    = left;
    assign cmd.right_speed   = right;
    assign cmd.avoiding_flag = avoid_next;
    assign cmd.around_flag   = around_next;
    assign cmd.recovery_flag = recover_next;
    assign cmd.on_track_flag = on_track_next;

    // Commit the mode state when the transaction moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_track_reg   <= 1'b1;
            avoid_reg      <= 1'b0;
            around_reg     <= 1'b0;
            recover_reg    <= 1'b0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else if (advance)
        begin
            on_track_reg   <= on_track_next;
            avoid_reg      <= avoid_next;
            around_reg     <= around_next;
            recover_reg    <= recover_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    // Recovery and line following are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n) on_track_reg != recover_reg)
        else $error("on_track and recovery both set or both clear");

    // Held speeds change only on an on-track tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !on_track_reg) |=> ($stable(held_left_reg) && $stable(held_right_reg)))
        else $error("held speeds changed off track");

    // Mode state holds while no transaction advances
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(avoid_reg) && $stable(around_reg) && $stable(recover_reg)
                      && $stable(on_track_reg)))
        else $error("mode state changed without a transaction");

endmodule

### hw/rtl/line_follow_obstacle_bypass_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// sensor    in         sensor_valid / sensor_ready   lfob_pkg::sensor_t
// cmd       out        cmd_valid / cmd_ready         lfob_pkg::cmd_t
// apb       in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while cmd is not stalled; a result is offered
// on cmd from the result register, after its sensor transaction is accepted into the input register.
// The mode chain and line law sit between those two registers as combinational logic.
// Reset restores register defaults, on-track mode and zero held speeds.
// A stalled cmd holds its result; a new sensor transaction is still taken
// while the input register is empty or moving on.

module line_follow_obstacle_bypass_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sensor_valid,
    output logic                           sensor_ready,
    input  lfob_pkg::sensor_t              sensor,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output lfob_pkg::cmd_t                 cmd,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfob_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lfob_pkg::DATA_BITS-1:0] pwdata,
    output logic [lfob_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    lfob_pkg::cfg_t    cfg;
    lfob_pkg::wheel_t  law;
    lfob_pkg::cmd_t    cmd_calc;
    lfob_pkg::sensor_t sensor_reg;
    lfob_pkg::cmd_t    cmd_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    lfob_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfob_line_law u_law
    (
        .item (sensor_reg),
        .fwd  (cfg.line_forward_speed),
        .law  (law)
    );

    lfob_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (sensor_reg),
        .cfg     (cfg),
        .law     (law),
        .cmd     (cmd_calc)
    );

    // Advance when the result register is free or being drained
    assign advance      = in_valid_reg && (!out_valid_reg || cmd_ready);
    assign sensor_ready = !in_valid_reg || advance;
    assign cmd_valid    = out_valid_reg;
    assign cmd          = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sensor_ready)
                in_valid_reg <= sensor_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (cmd_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sensor_ready && sensor_valid)
            sensor_reg <= sensor;
        if (advance)
            cmd_reg <= cmd_calc;
    end

endmodule
